### sv/fcp_pkg.sv
// Shared types and constants of the frame chunk packetizer.
package fcp_pkg;

  // Header layout: magic, frame id, chunk index, chunk count, frame size.
  localparam int unsigned HdrBytes = 16;
  localparam int unsigned HdrIdxW  = $clog2(HdrBytes);

  // Chunk count divider: 33-bit dividend, one quotient bit per step.
  localparam int unsigned DivSteps = 33;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgPayload  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMagic    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxFrame = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] PayloadReset  = 16'd1400;
  localparam logic [31:0] MagicReset    = 32'd0;
  localparam logic [31:0] MaxFrameReset = 32'd1048576;

  // Kind of result loaded into the output register.
  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_REJECT,
    EMIT_HEADER,
    EMIT_DATA
  } fcp_emit_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      capture;
    logic      clear_open;
    logic      div_start;
    logic      commit;
    fcp_emit_e emit;
  } fcp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_data;
    logic too_big;
    logic len_zero;
    logic div_done;
    logic frame_open;
    logic fill_zero;
    logic hdr_last;
    logic out_free;
  } fcp_sts_t;

endpackage

### sv/fcp_div.sv
// Bit-serial restoring divider that yields the low 16 bits of the chunk count.
module fcp_div import fcp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [15:0] quot_o
);

  localparam int unsigned CntW = $clog2(DivSteps);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [32:0]     num_q, num_d;
  logic [15:0]     rem_q, rem_d;
  logic [15:0]     quot_q, quot_d;
  logic [16:0]     trial;
  logic [16:0]     diff;
  logic            take;

  // One quotient bit per cycle, dividend bits shifted in from the top.
  always_comb begin
    trial  = {rem_q, num_q[32]};
    diff   = trial - {1'b0, divisor_i};
    take   = (trial >= {1'b0, divisor_i});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DivSteps - 1);
      num_d  = dividend_i;
      rem_d  = '0;
      quot_d = '0;
    end else if (busy_q) begin
      num_d  = {num_q[31:0], 1'b0};
      rem_d  = take ? diff[15:0] : trial[15:0];
      quot_d = {quot_q[14:0], take};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CntW'(1);
      end
    end
  end

  // Divider registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### sv/fcp_dp.sv
// Datapath of the packetizer: item, configuration and frame registers, header
// byte selection and the output register.
module fcp_dp import fcp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fcp_cmd_t           cmd_i,
  output fcp_sts_t           sts_o,
  input  logic               req_type_i,
  input  logic [7:0]         data_byte_i,
  input  logic [31:0]        frame_length_i,
  input  logic [31:0]        frame_number_i,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               packet_end_o,
  output logic               run_end_o,
  output logic               status_o
);

  // Captured input item.
  logic        req_q;
  logic [7:0]  byte_q;
  logic [31:0] len_q;
  logic [31:0] fid_q;

  // Configuration registers.
  logic [15:0] payload_q;
  logic [31:0] magic_q;
  logic [31:0] max_frame_q;

  // Frame state.
  logic [31:0] cur_size_q, cur_size_d;
  logic [31:0] cur_id_q, cur_id_d;
  logic [31:0] taken_q, taken_d;
  logic [15:0] chunk_idx_q, chunk_idx_d;
  logic [15:0] chunk_total_q, chunk_total_d;
  logic [15:0] fill_q, fill_d;
  logic        open_q, open_d;
  logic [HdrIdxW-1:0] hdr_cnt_q, hdr_cnt_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        pend_q, pend_d;
  logic        rend_q, rend_d;
  logic        status_q, status_d;

  logic [15:0]  eff_payload;
  logic [32:0]  dividend;
  logic         div_done;
  logic [15:0]  quot;
  logic [127:0] hdr_vec;
  logic [7:0]   hdr_byte;
  logic         hdr_last;
  logic [31:0]  taken_inc;
  logic [15:0]  fill_inc;
  logic [15:0]  idx_inc;
  logic         all_taken;
  logic         data_end;
  logic         out_free;

  // A payload size of zero behaves as one.
  assign eff_payload = (payload_q == '0) ? 16'd1 : payload_q;
  assign dividend    = {1'b0, len_q} + {17'd0, eff_payload} - 33'd1;

  fcp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (eff_payload),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Header bytes go out most significant first.
  assign hdr_vec  = {magic_q, cur_id_q, chunk_idx_q, chunk_total_q, cur_size_q};
  assign hdr_byte = hdr_vec[8*(HdrBytes-1-int'(hdr_cnt_q)) +: 8];
  assign hdr_last = (hdr_cnt_q == HdrIdxW'(HdrBytes - 1));

  // End of packet test for the data byte being sent.
  assign taken_inc = taken_q + 32'd1;
  assign fill_inc  = fill_q + 16'd1;
  assign idx_inc   = chunk_idx_q + 16'd1;
  assign all_taken = (taken_inc == cur_size_q);
  assign data_end  = all_taken || (fill_inc >= eff_payload);

  assign out_free = !out_valid_q || !out_stall_i;

  // Frame state and output register next values.
  always_comb begin
    cur_size_d    = cur_size_q;
    cur_id_d      = cur_id_q;
    taken_d       = taken_q;
    chunk_idx_d   = chunk_idx_q;
    chunk_total_d = chunk_total_q;
    fill_d        = fill_q;
    open_d        = open_q;
    hdr_cnt_d     = hdr_cnt_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_byte_d    = out_byte_q;
    pend_d        = pend_q;
    rend_d        = rend_q;
    status_d      = status_q;

    if (cmd_i.clear_open) begin
      open_d = 1'b0;
    end
    if (cmd_i.commit) begin
      cur_size_d    = len_q;
      cur_id_d      = fid_q;
      taken_d       = '0;
      chunk_idx_d   = '0;
      chunk_total_d = (quot == '0) ? 16'd1 : quot;
      fill_d        = '0;
      open_d        = (len_q != '0);
      hdr_cnt_d     = '0;
    end

    unique case (cmd_i.emit)
      EMIT_NONE: begin
      end
      EMIT_REJECT: begin
        out_valid_d = 1'b1;
        out_byte_d  = 8'd0;
        pend_d      = 1'b0;
        rend_d      = 1'b1;
        status_d    = 1'b1;
      end
      EMIT_HEADER: begin
        // A header closes its packet only for an empty frame.
        out_valid_d = 1'b1;
        out_byte_d  = hdr_byte;
        pend_d      = hdr_last && !req_q;
        rend_d      = hdr_last && !req_q;
        status_d    = 1'b0;
        hdr_cnt_d   = hdr_cnt_q + HdrIdxW'(1);
      end
      EMIT_DATA: begin
        out_valid_d = 1'b1;
        out_byte_d  = byte_q;
        pend_d      = data_end;
        rend_d      = 1'b1;
        status_d    = 1'b0;
        taken_d     = taken_inc;
        if (data_end) begin
          fill_d      = '0;
          chunk_idx_d = idx_inc;
          if (all_taken || (idx_inc == chunk_total_q)) begin
            open_d = 1'b0;
          end
        end else begin
          fill_d = fill_inc;
        end
      end
    endcase
  end

  // Control and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_q     <= PayloadReset;
      magic_q       <= MagicReset;
      max_frame_q   <= MaxFrameReset;
      cur_size_q    <= '0;
      cur_id_q      <= '0;
      taken_q       <= '0;
      chunk_idx_q   <= '0;
      chunk_total_q <= '0;
      fill_q        <= '0;
      open_q        <= 1'b0;
      hdr_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgPayload) begin
          payload_q <= cfg_data_i[15:0];
        end
        if (cfg_index_i == CfgMagic) begin
          magic_q <= cfg_data_i;
        end
        if (cfg_index_i == CfgMaxFrame) begin
          max_frame_q <= cfg_data_i;
        end
      end
      cur_size_q    <= cur_size_d;
      cur_id_q      <= cur_id_d;
      taken_q       <= taken_d;
      chunk_idx_q   <= chunk_idx_d;
      chunk_total_q <= chunk_total_d;
      fill_q        <= fill_d;
      open_q        <= open_d;
      hdr_cnt_q     <= hdr_cnt_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_type_i;
      byte_q <= data_byte_i;
      len_q  <= frame_length_i;
      fid_q  <= frame_number_i;
    end
    out_byte_q <= out_byte_d;
    pend_q     <= pend_d;
    rend_q     <= rend_d;
    status_q   <= status_d;
  end

  // Status toward the controller.
  always_comb begin
    sts_o.req_data   = req_q;
    sts_o.too_big    = (len_q > max_frame_q);
    sts_o.len_zero   = (len_q == '0);
    sts_o.div_done   = div_done;
    sts_o.frame_open = open_q;
    sts_o.fill_zero  = (fill_q == '0);
    sts_o.hdr_last   = hdr_last;
    sts_o.out_free   = out_free;
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign packet_end_o = pend_q;
  assign run_end_o    = rend_q;
  assign status_o     = status_q;

endmodule

### sv/fcp_ctrl.sv
// Controller state machine that sequences one input item at a time.
module fcp_ctrl import fcp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  fcp_sts_t sts_i,
  output fcp_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CHECK  = 6'b000010,
    ST_REJECT = 6'b000100,
    ST_DIV    = 6'b001000,
    ST_HEADER = 6'b010000,
    ST_DATA   = 6'b100000
  } fcp_state_e;

  fcp_state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_d          = state_q;
    cmd_o.capture    = 1'b0;
    cmd_o.clear_open = 1'b0;
    cmd_o.div_start  = 1'b0;
    cmd_o.commit     = 1'b0;
    cmd_o.emit       = EMIT_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!sts_i.req_data) begin
          // Any frame start abandons the open frame.
          cmd_o.clear_open = 1'b1;
          if (sts_i.too_big) begin
            state_d = ST_REJECT;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV;
          end
        end else if (!sts_i.frame_open) begin
          state_d = ST_IDLE;
        end else if (sts_i.fill_zero) begin
          state_d = ST_HEADER;
        end else begin
          state_d = ST_DATA;
        end
      end
      ST_REJECT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = EMIT_REJECT;
          state_d    = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.commit = 1'b1;
          state_d      = sts_i.len_zero ? ST_HEADER : ST_IDLE;
        end
      end
      ST_HEADER: begin
        if (sts_i.out_free) begin
          cmd_o.emit = EMIT_HEADER;
          if (sts_i.hdr_last) begin
            state_d = sts_i.req_data ? ST_DATA : ST_IDLE;
          end
        end
      end
      ST_DATA: begin
        if (sts_i.out_free) begin
          cmd_o.emit = EMIT_DATA;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### sv/frame_chunk_packetizer_unit.sv
// Frame chunk packetizer: takes one item at a time. A data byte passes through
// the check and data states to its result, and when it opens a packet its
// header goes out first; a data byte with no open frame is dropped after the
// check. A frame start waits for the bit-serial chunk count divider (33 steps),
// and an empty frame then sends its sixteen header bytes; a rejected frame
// start yields a lone rejection result. A stalled output holds back each
// result. The configuration port is always ready and must be written only
// while the block is idle.
module frame_chunk_packetizer_unit import fcp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [7:0]         data_byte_i,
  input  logic [31:0]        frame_length_i,
  input  logic [31:0]        frame_number_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               packet_end_o,
  output logic               run_end_o,
  output logic               status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  fcp_cmd_t dp_cmd;
  fcp_sts_t dp_sts;

  assign cfg_ready_o = 1'b1;

  // Controller.
  fcp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  // Datapath.
  fcp_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .sts_o          (dp_sts),
    .req_type_i     (req_type_i),
    .data_byte_i    (data_byte_i),
    .frame_length_i (frame_length_i),
    .frame_number_i (frame_number_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .packet_end_o   (packet_end_o),
    .run_end_o      (run_end_o),
    .status_o       (status_o)
  );

`ifndef SYNTHESIS
  // Only one item is in work at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted twice in a row");

  // A rejection result is a lone zero result that ends its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (run_end_o && !packet_end_o && out_byte_o == 8'd0))
    else $error("malformed rejection result");

  // The controller never overwrites a result that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd.emit != EMIT_NONE) |-> dp_sts.out_free)
    else $error("result emitted into a full output register");
`endif

endmodule

### verif/testbench.sv
// Self-checking testbench for the frame chunk packetizer unit.
`timescale 1ns / 1ps

module testbench;
  import fcp_pkg::*;

  localparam int unsigned IdleLimit   = 5000;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned PhaseItems  = 22;

  localparam logic ReqStart = 1'b0;
  localparam logic ReqData  = 1'b1;
  localparam logic StPacket = 1'b0;
  localparam logic StReject = 1'b1;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN
  } stall_mode_e;

  // One byte of packet output as it should appear on the result port.
  typedef struct packed {
    logic [7:0] byt;
    logic       pkt_end;
    logic       run_end;
    logic       status;
  } pkt_beat_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic               req_type_i     = ReqStart;
  logic [7:0]         data_byte_i    = 8'h00;
  logic [31:0]        frame_length_i = 32'h0;
  logic [31:0]        frame_number_i = 32'h0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic [7:0]         out_byte_o;
  logic               packet_end_o;
  logic               run_end_o;
  logic               status_o;
  logic               cfg_valid_i    = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i    = CfgPayload;
  logic [31:0]        cfg_data_i     = 32'h0;

  // Packetizer shadow: configuration and frame state.
  logic [15:0] cfg_payload   = PayloadReset;
  logic [31:0] cfg_magic     = MagicReset;
  logic [31:0] cfg_max_frame = MaxFrameReset;
  logic [31:0] frm_size      = 32'h0;
  logic [31:0] frm_id        = 32'h0;
  logic [31:0] frm_taken     = 32'h0;
  logic [15:0] chunk_idx     = 16'h0;
  logic [15:0] chunk_cnt     = 16'h0;
  logic [15:0] chunk_fill    = 16'h0;
  logic        frm_open      = 1'b0;

  pkt_beat_t   pending_beats[$];
  int unsigned sent_items  = 0;
  int unsigned fails       = 0;
  int unsigned burst_left  = 0;
  bit          gaps_on     = 1'b1;
  stall_mode_e stall_mode  = STALL_NONE;
  bit          hold_req    = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned stall_phase = 0;
  int unsigned quiet       = 0;

  frame_chunk_packetizer_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .data_byte_i    (data_byte_i),
    .frame_length_i (frame_length_i),
    .frame_number_i (frame_number_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .packet_end_o   (packet_end_o),
    .run_end_o      (run_end_o),
    .status_o       (status_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void push_beat(logic [7:0] b, logic pe, logic st);
    pkt_beat_t beat;
    beat.byt     = b;
    beat.pkt_end = pe;
    beat.run_end = 1'b0;
    beat.status  = st;
    pending_beats.push_back(beat);
  endfunction

  // The 16 header bytes, most significant byte of each field first.
  function automatic void push_header(logic last_is_end);
    logic [127:0] hdr;
    hdr = {cfg_magic, frm_id, chunk_idx, chunk_cnt, frm_size};
    for (int i = 0; i < 16; i++) begin
      push_beat(hdr[127-8*i -: 8], last_is_end && (i == 15), StPacket);
    end
  endfunction

  // Works out the packet bytes caused by one accepted transaction.
  function automatic void predict_packets(logic req, logic [7:0] b, logic [31:0] len,
                                          logic [31:0] fid);
    int unsigned n_before;
    logic [32:0] eff;
    logic [32:0] quot;
    logic [15:0] chunks;
    logic        last;
    pkt_beat_t   tail;
    n_before = pending_beats.size();
    eff = (cfg_payload == 16'd0) ? 33'd1 : {17'd0, cfg_payload};
    if (req == ReqStart) begin
      frm_open = 1'b0;
      if (len > cfg_max_frame) begin
        push_beat(8'h00, 1'b0, StReject);
      end else begin
        quot   = ({1'b0, len} + eff - 33'd1) / eff;
        chunks = quot[15:0];
        if (chunks == 16'd0) chunks = 16'd1;
        frm_size   = len;
        frm_id     = fid;
        frm_taken  = 32'h0;
        chunk_idx  = 16'h0;
        chunk_cnt  = chunks;
        chunk_fill = 16'h0;
        if (len == 32'h0) push_header(1'b1);
        else frm_open = 1'b1;
      end
    end else if (frm_open) begin
      if (chunk_fill == 16'h0) push_header(1'b0);
      frm_taken++;
      chunk_fill++;
      last = (frm_taken == frm_size) || ({17'd0, chunk_fill} >= eff);
      push_beat(b, last, StPacket);
      if (last) begin
        chunk_fill = 16'h0;
        chunk_idx++;
        if (frm_taken == frm_size || chunk_idx == chunk_cnt) frm_open = 1'b0;
      end
    end
    // The last byte caused by a transaction carries run_end.
    if (pending_beats.size() > n_before) begin
      tail = pending_beats.pop_back();
      tail.run_end = 1'b1;
      pending_beats.push_back(tail);
    end
  endfunction

  // Track accepted input and configuration transactions.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_packets(req_type_i, data_byte_i, frame_length_i, frame_number_i);
    end
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgPayload:  cfg_payload   = cfg_data_i[15:0];
        CfgMagic:    cfg_magic     = cfg_data_i;
        CfgMaxFrame: cfg_max_frame = cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic void check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      fails++;
    end
  endfunction

  // Compare each output transaction with the oldest expected byte.
  always @(posedge clk_i) begin : result_check
    pkt_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected result: out_byte %0h status %0b", out_byte_o, status_o);
        fails++;
      end else begin
        want = pending_beats.pop_front();
        check_field("out_byte", want.byt, out_byte_o);
        check_field("packet_end", want.pkt_end, packet_end_o);
        check_field("run_end", want.run_end, run_end_o);
        check_field("status", want.status, status_o);
      end
    end
  end

  // Receiver stall pattern, with an occasional long hold-off on request.
  always @(posedge clk_i) begin
    stall_phase++;
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_RANDOM:  out_stall_i <= ($urandom_range(0, 2) == 0);
        STALL_PATTERN: out_stall_i <= ((stall_phase % 7) < 3);
        default:       out_stall_i <= 1'b0;
      endcase
    end
  end

  // Watchdog: ends the run when no transaction completes for too long.
  initial begin : watchdog
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("testbench: FAIL");
    $finish;
  end

  // Offers one item; the sender idles between bursts of random length.
  task automatic send_item(logic req, logic [7:0] b, logic [31:0] len, logic [31:0] fid);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    sent_items++;
    in_valid_i     <= 1'b1;
    req_type_i     <= req;
    data_byte_i    <= b;
    frame_length_i <= len;
    frame_number_i <= fid;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_start(logic [31:0] len, logic [31:0] fid);
    send_item(ReqStart, 8'($urandom_range(0, 255)), len, fid);
  endtask

  task automatic send_data(logic [7:0] b);
    send_item(ReqData, b, $urandom, $urandom);
  endtask

  // Lets all expected bytes arrive, then allows for items without output.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_config(logic [15:0] payload, logic [31:0] magic, logic [31:0] max_len);
    cfg_write(CfgPayload, {16'h0, payload});
    cfg_write(CfgMagic, magic);
    cfg_write(CfgMaxFrame, max_len);
    cfg_valid_i <= 1'b0;
  endtask

  // Reset configuration: stray data, an empty frame, surplus bytes.
  task automatic test_reset_values();
    send_data(8'hFF);
    send_start(32'h0, 32'hFFFF_FFFF);
    send_start(32'd3, 32'h0000_0001);
    send_data(8'h00);
    send_data(8'hFF);
    send_data(8'h5A);
    send_data(8'h11);
    wait_drained();
  endtask

  // Register extremes: zero payload, chunk count wrap, zero size limit.
  task automatic test_config_extremes();
    set_config(16'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_start(32'd2, 32'h8000_0001);
    send_data(8'hA5);
    send_data(8'h3C);
    // The chunk count wraps to zero and is forced to one packet.
    send_start(32'h0001_0000, 32'h0);
    send_data(8'hC3);
    send_data(8'h96);
    wait_drained();
    set_config(16'hFFFF, 32'h0, 32'h0);
    send_start(32'hFFFF_FFFF, 32'h7);
    send_data(8'h01);
    send_start(32'h0, 32'h8);
    wait_drained();
  endtask

  // A new frame start cuts off a packet in the middle.
  task automatic test_abandoned_frame();
    set_config(16'd2, 32'h1234_5678, 32'd16);
    send_start(32'd5, 32'd9);
    repeat (3) send_data(8'($urandom_range(0, 255)));
    send_start(32'd3, 32'd10);
    repeat (3) send_data(8'($urandom_range(0, 255)));
    wait_drained();
  endtask

  // Long receiver hold-off while the sender keeps offering items.
  task automatic test_backpressure();
    set_config(16'd5, $urandom, 32'd1000);
    stall_mode = STALL_RANDOM;
    gaps_on    = 1'b0;
    hold_req   = 1'b1;
    send_start(32'd30, $urandom);
    repeat (30) send_data(8'($urandom_range(0, 255)));
    send_start(32'd8, $urandom);
    repeat (8) send_data(8'($urandom_range(0, 255)));
    wait_drained();
  endtask

  // One random frame sequence, mostly well formed.
  task automatic send_random_unit();
    int unsigned kind;
    int unsigned len;
    int unsigned nbytes;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      send_data(8'($urandom_range(0, 255)));
    end else if (kind == 1) begin
      send_start($urandom, $urandom);
      repeat ($urandom_range(0, 2)) send_data(8'($urandom_range(0, 255)));
    end else if (kind == 2) begin
      send_start($urandom_range(41, 200), $urandom);
      repeat ($urandom_range(1, 5)) send_data(8'($urandom_range(0, 255)));
    end else begin
      len    = $urandom_range(0, 40);
      nbytes = len;
      if (kind == 3) nbytes = len + $urandom_range(1, 3);
      if (kind == 4 && len > 0) nbytes = $urandom_range(0, len - 1);
      send_start(len, $urandom);
      repeat (nbytes) send_data(8'($urandom_range(0, 255)));
    end
  endtask

  // Six register settings, with varied receiver stall and sender idling patterns.
  task automatic test_random_traffic();
    logic [15:0] payload;
    logic [31:0] max_len;
    int unsigned target;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       payload = 16'd1;
        1:       payload = 16'd3;
        2:       payload = 16'hFFFF;
        default: payload = 16'($urandom_range(1, 24));
      endcase
      max_len    = (phase == 3) ? 32'hFFFF_FFFF : $urandom_range(0, 48);
      stall_mode = stall_mode_e'(phase % 3);
      gaps_on    = (phase != 1);
      set_config(payload, $urandom, max_len);
      target = sent_items + PhaseItems;
      while (sent_items < target) send_random_unit();
      wait_drained();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_config_extremes();
    test_abandoned_frame();
    test_backpressure();
    test_random_traffic();
    if (fails == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
